// ----- design/bfu_pkg.sv -----
// Package for the bilinear frame upscaler: field widths, register indexes,
// item modes and the per-channel interpolation step. No dependencies.
package bfu_pkg;

  localparam int COORD_W   = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 24;
  localparam int ARGB_W    = 32;
  localparam int FRAC_W    = 9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] OUT_WIDTH_RST  = 13'd320;
  localparam logic [CFG_W-1:0] OUT_HEIGHT_RST = 13'd240;

  // Item modes.
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [FRAC_W-1:0] FRAC_ONE     = 9'd256;

  // One interpolation step: a + floor((b - a) * f / 256), with f in 0..256.
  function automatic logic [CHAN_W-1:0] bfu_lerp(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b,
                                                 input logic [FRAC_W-1:0] f);
    logic signed [9:0]  diff;
    logic signed [19:0] prod;
    logic signed [19:0] sum;
    diff = $signed({2'b00, b}) - $signed({2'b00, a});
    prod = diff * $signed({1'b0, f});
    sum  = (prod >>> 8) + $signed({12'd0, a});
    return sum[CHAN_W-1:0];
  endfunction

endpackage

// ----- design/bfu_if.sv -----
// Valid/ready channel interfaces for the upscaler's input and result streams.
// Depends on bfu_pkg for the field widths.
interface bfu_in_if;
  import bfu_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;

  modport source (output valid, mode, pos_x, pos_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, mode, pos_x, pos_y, red_in, green_in, blue_in,
                  output ready);
endinterface

interface bfu_out_if;
  import bfu_pkg::*;
  logic              valid;
  logic              ready;
  logic [ARGB_W-1:0] argb_word;

  modport source (output valid, argb_word, input ready);
  modport sink   (input valid, argb_word, output ready);
endinterface

// ----- design/bfu_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bfu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 19200
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- design/bfu_coord_map.sv -----
// Maps an output coordinate to a source index and 8-bit fraction through a
// pipelined restoring divider, one quotient bit per stage. Depends on bfu_pkg.
module bfu_coord_map #(
  parameter int SRC = 320,
  parameter int QB  = 9
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [bfu_pkg::COORD_W-1:0] coord_i,
  input  logic [bfu_pkg::CFG_W-1:0]  out_size_i,
  output logic [QB-1:0]              idx_o,
  output logic [bfu_pkg::FRAC_W-1:0] frac_o
);
  import bfu_pkg::*;

  localparam int NS = QB + 8;            // quotient bits, one per stage
  localparam int PW = COORD_W + QB;      // coord * (SRC - 1)
  localparam int RW = PW + 8;            // scaled dividend and remainder
  localparam int LW = CFG_W + QB;        // divisor * (SRC - 1)

  logic [CFG_W-1:0] div_d;
  logic [CFG_W-1:0] div_q;
  logic [LW-1:0]    lim_q;
  logic [PW-1:0]    prod_q;
  logic [RW-1:0]    rem_q   [NS+1];
  logic [NS-1:0]    quo_q   [NS+1];
  logic             clamp_q [NS+1];

  // Divisor is out_size - 1, or 1 for sizes of 0 and 1; it follows the register.
  assign div_d = (out_size_i > CFG_W'(1)) ? (out_size_i - CFG_W'(1)) : CFG_W'(1);

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    lim_q <= LW'(div_q) * LW'(SRC - 1);
  end

  // Scale, clamp test, then one compare and subtract per quotient bit.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q     <= PW'(coord_i) * PW'(SRC - 1);
      clamp_q[0] <= (LW'(prod_q) >= lim_q);
      rem_q[0]   <= {prod_q, 8'd0};
      quo_q[0]   <= '0;
      for (int s = 0; s < NS; s++) begin
        if (rem_q[s] >= (RW'(div_q) << (NS - 1 - s))) begin
          rem_q[s+1] <= rem_q[s] - (RW'(div_q) << (NS - 1 - s));
          quo_q[s+1] <= quo_q[s] | (NS'(1) << (NS - 1 - s));
        end else begin
          rem_q[s+1] <= rem_q[s];
          quo_q[s+1] <= quo_q[s];
        end
        clamp_q[s+1] <= clamp_q[s];
      end
    end
  end

  // Past the last cell the index sticks at SRC-2 with the full weight.
  assign idx_o  = clamp_q[NS] ? QB'(SRC - 2) : quo_q[NS][NS-1:8];
  assign frac_o = clamp_q[NS] ? FRAC_ONE : {1'b0, quo_q[NS][7:0]};

endmodule

// ----- design/bilinear_frame_upscaler_unit.sv -----
// Bilinear frame upscaler: top level. Depends on bfu_pkg, bfu_if, bfu_ram
// and bfu_coord_map.
// Throughput: one transaction per cycle while the output buffer has room or the receiver
// is ready, writes and requests mixed freely.
// Reset clears the pipeline valids and empties the output buffer, and loads the size registers
// with 320 x 240; the frame store is not cleared and holds garbage until written.
module bilinear_frame_upscaler_unit #(
  parameter int SRC_WIDTH  = 320,
  parameter int SRC_HEIGHT = 240
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bfu_in_if.sink                        in_i,
  bfu_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [bfu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bfu_pkg::CFG_W-1:0]     cfg_data_i
);
  import bfu_pkg::*;

  localparam int QBX        = $clog2(SRC_WIDTH);
  localparam int QBY        = $clog2(SRC_HEIGHT);
  localparam int QB         = (QBX > QBY) ? QBX : QBY;
  localparam int MAPLAT     = QB + 10;
  localparam int HALF_W     = (SRC_WIDTH + 1) / 2;
  localparam int HALF_H     = (SRC_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Configuration registers.
  logic [CFG_W-1:0] out_width_q;
  logic [CFG_W-1:0] out_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_width_q  <= OUT_WIDTH_RST;
      out_height_q <= OUT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUT_WIDTH:  out_width_q  <= cfg_data_i;
        CFG_OUT_HEIGHT: out_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together while the output buffer has room.
  logic       en;
  logic [1:0] obuf_cnt_q;
  assign en         = (obuf_cnt_q != 2'd2) || out_o.ready;
  assign in_i.ready = en;

  // Input stage.
  logic               s0_v_q;
  logic               s0_mode_q;
  logic [COORD_W-1:0] s0_x_q;
  logic [COORD_W-1:0] s0_y_q;
  logic [PIX_W-1:0]   s0_rgb_q;

  // Sideband line alongside the coordinate mapping.
  logic               sb_v_q    [MAPLAT];
  logic               sb_mode_q [MAPLAT];
  logic [COORD_W-1:0] sb_x_q    [MAPLAT];
  logic [COORD_W-1:0] sb_y_q    [MAPLAT];
  logic [PIX_W-1:0]   sb_rgb_q  [MAPLAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      for (int i = 0; i < MAPLAT; i++) begin
        sb_v_q[i] <= 1'b0;
      end
    end else if (en) begin
      s0_v_q    <= in_i.valid;
      sb_v_q[0] <= s0_v_q;
      for (int i = 1; i < MAPLAT; i++) begin
        sb_v_q[i] <= sb_v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_mode_q    <= in_i.mode;
      s0_x_q       <= in_i.pos_x;
      s0_y_q       <= in_i.pos_y;
      s0_rgb_q     <= {in_i.red_in, in_i.green_in, in_i.blue_in};
      sb_mode_q[0] <= s0_mode_q;
      sb_x_q[0]    <= s0_x_q;
      sb_y_q[0]    <= s0_y_q;
      sb_rgb_q[0]  <= s0_rgb_q;
      for (int i = 1; i < MAPLAT; i++) begin
        sb_mode_q[i] <= sb_mode_q[i-1];
        sb_x_q[i]    <= sb_x_q[i-1];
        sb_y_q[i]    <= sb_y_q[i-1];
        sb_rgb_q[i]  <= sb_rgb_q[i-1];
      end
    end
  end

  // Source position of each request, column and row in parallel.
  logic [QB-1:0]     idx_x;
  logic [QB-1:0]     idx_y;
  logic [FRAC_W-1:0] frac_x;
  logic [FRAC_W-1:0] frac_y;

  bfu_coord_map #(.SRC(SRC_WIDTH), .QB(QB)) u_map_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .coord_i    (s0_x_q),
    .out_size_i (out_width_q),
    .idx_o      (idx_x),
    .frac_o     (frac_x)
  );

  bfu_coord_map #(.SRC(SRC_HEIGHT), .QB(QB)) u_map_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .coord_i    (s0_y_q),
    .out_size_i (out_height_q),
    .idx_o      (idx_y),
    .frac_o     (frac_y)
  );

  // The frame is split into four banks by row and column parity, so the
  // four neighbours of a cell always sit in different banks.
  logic               map_req;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [COORD_W:0]   col_sum [2];
  logic [COORD_W:0]   row_sum [2];

  assign map_req = (sb_mode_q[MAPLAT-1] == MODE_REQUEST);
  assign cx = map_req ? COORD_W'(idx_x) : sb_x_q[MAPLAT-1];
  assign cy = map_req ? COORD_W'(idx_y) : sb_y_q[MAPLAT-1];

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      col_sum[p] = (COORD_W + 1)'(cx) + (COORD_W + 1)'(cx[0] != p[0]);
      row_sum[p] = (COORD_W + 1)'(cy) + (COORD_W + 1)'(cy[0] != p[0]);
    end
  end

  // Address stage: row offsets per parity and column halves.
  logic               p1_v_q;
  logic               p1_req_q;
  logic               p1_wr_ok_q;
  logic [1:0]         p1_wbank_q;
  logic [BAW-1:0]     p1_rowoff_q [2];
  logic [COORD_W-1:0] p1_colh_q   [2];
  logic               p1_px_q;
  logic               p1_py_q;
  logic [FRAC_W-1:0]  p1_fx_q;
  logic [FRAC_W-1:0]  p1_fy_q;
  logic [PIX_W-1:0]   p1_rgb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_req_q   <= map_req;
      p1_wr_ok_q <= (32'(sb_x_q[MAPLAT-1]) < SRC_WIDTH) &&
                    (32'(sb_y_q[MAPLAT-1]) < SRC_HEIGHT);
      p1_wbank_q <= {cy[0], cx[0]};
      for (int p = 0; p < 2; p++) begin
        p1_rowoff_q[p] <= BAW'(32'(row_sum[p][COORD_W:1]) * HALF_W);
        p1_colh_q[p]   <= col_sum[p][COORD_W:1];
      end
      p1_px_q  <= cx[0];
      p1_py_q  <= cy[0];
      p1_fx_q  <= frac_x;
      p1_fy_q  <= frac_y;
      p1_rgb_q <= sb_rgb_q[MAPLAT-1];
    end
  end

  // Frame store banks, indexed {row parity, column parity}.
  logic             ram_we    [4];
  logic             ram_re    [4];
  logic [BAW-1:0]   ram_addr  [4];
  logic [PIX_W-1:0] ram_rdata [4];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      ram_addr[b] = p1_rowoff_q[b / 2] + BAW'(p1_colh_q[b % 2]);
      ram_re[b]   = en && p1_v_q && p1_req_q;
      ram_we[b]   = en && p1_v_q && !p1_req_q && p1_wr_ok_q && (p1_wbank_q == 2'(b));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bfu_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[b]),
      .waddr_i (ram_addr[b]),
      .wdata_i (p1_rgb_q),
      .re_i    (ram_re[b]),
      .raddr_i (ram_addr[b]),
      .rdata_o (ram_rdata[b])
    );
  end

  // Read data stage: the bank read registers hold the four neighbours.
  logic              p2_v_q;
  logic              p2_px_q;
  logic              p2_py_q;
  logic [FRAC_W-1:0] p2_fx_q;
  logic [FRAC_W-1:0] p2_fy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_px_q <= p1_px_q;
      p2_py_q <= p1_py_q;
      p2_fx_q <= p1_fx_q;
      p2_fy_q <= p1_fy_q;
    end
  end

  logic [PIX_W-1:0] pix_a;
  logic [PIX_W-1:0] pix_b;
  logic [PIX_W-1:0] pix_c;
  logic [PIX_W-1:0] pix_d;

  assign pix_a = ram_rdata[{p2_py_q,  p2_px_q}];
  assign pix_b = ram_rdata[{p2_py_q, ~p2_px_q}];
  assign pix_c = ram_rdata[{~p2_py_q,  p2_px_q}];
  assign pix_d = ram_rdata[{~p2_py_q, ~p2_px_q}];

  // Horizontal step for the upper and lower rows.
  logic              p3_v_q;
  logic [PIX_W-1:0]  p3_top_q;
  logic [PIX_W-1:0]  p3_bot_q;
  logic [FRAC_W-1:0] p3_fy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p3_top_q[k*CHAN_W +: CHAN_W] <= bfu_lerp(pix_a[k*CHAN_W +: CHAN_W],
                                                 pix_b[k*CHAN_W +: CHAN_W], p2_fx_q);
        p3_bot_q[k*CHAN_W +: CHAN_W] <= bfu_lerp(pix_c[k*CHAN_W +: CHAN_W],
                                                 pix_d[k*CHAN_W +: CHAN_W], p2_fx_q);
      end
      p3_fy_q <= p2_fy_q;
    end
  end

  // Vertical step and packing.
  logic [PIX_W-1:0]  rgb_out;
  logic [ARGB_W-1:0] argb;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rgb_out[k*CHAN_W +: CHAN_W] = bfu_lerp(p3_top_q[k*CHAN_W +: CHAN_W],
                                             p3_bot_q[k*CHAN_W +: CHAN_W], p3_fy_q);
    end
  end
  assign argb = {ALPHA_OPAQUE, rgb_out};

  // Stage valids; only requests travel past the address stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= sb_v_q[MAPLAT-1];
      p2_v_q <= p1_v_q && p1_req_q;
      p3_v_q <= p2_v_q;
    end
  end

  // Two-entry output buffer: the pipeline keeps moving while a result waits.
  logic              push;
  logic              pop;
  logic [ARGB_W-1:0] obuf0_q;
  logic [ARGB_W-1:0] obuf1_q;

  assign push = en && p3_v_q;
  assign pop  = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obuf_cnt_q <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   obuf_cnt_q <= obuf_cnt_q + 2'd1;
        2'b01:   obuf_cnt_q <= obuf_cnt_q - 2'd1;
        default: obuf_cnt_q <= obuf_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case ({push, pop})
      2'b10: begin
        if (obuf_cnt_q == 2'd0) begin
          obuf0_q <= argb;
        end else begin
          obuf1_q <= argb;
        end
      end
      2'b01: begin
        obuf0_q <= obuf1_q;
      end
      2'b11: begin
        if (obuf_cnt_q == 2'd1) begin
          obuf0_q <= argb;
        end else begin
          obuf0_q <= obuf1_q;
          obuf1_q <= argb;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid     = (obuf_cnt_q != 2'd0);
  assign out_o.argb_word = obuf0_q;

endmodule

// ----- tb/sv/bilinear_frame_upscaler_unit_test.sv -----
// Testbench for the bilinear frame upscaler unit: drives source pixel writes and
// output pixel requests, predicts each interpolated ARGB word and checks it.
// Depends on bfu_pkg, bfu_if and the bilinear_frame_upscaler_unit RTL.
`timescale 1ns / 100ps

module bilinear_frame_upscaler_unit_test;
  import bfu_pkg::*;

  localparam int SRC_W = 320;
  localparam int SRC_H = 240;
  localparam int LATENCY = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_OUT_WIDTH;
  logic [CFG_W-1:0] cfg_data_i = '0;

  bfu_in_if in_ch ();
  bfu_out_if out_ch ();

  bilinear_frame_upscaler_unit #(.SRC_WIDTH(SRC_W), .SRC_HEIGHT(SRC_H)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Predictor state: a copy of the frame and of the size registers.
  logic [PIX_W-1:0] frame_copy [SRC_W*SRC_H];
  bit written [SRC_W*SRC_H];
  logic [CFG_W-1:0] width_reg = OUT_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = OUT_HEIGHT_RST;
  logic [ARGB_W-1:0] pending_pixels [$];

  int error_count = 0;
  int idle_cycles = 0;
  bit sink_hold = 1'b0;
  bit steady_phase = 1'b0;

  initial forever #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_WRITE;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    out_ch.ready = 1'b0;
  end

  // Maps an output coordinate onto a source cell and an 8-bit fraction.
  function automatic void map_to_source(input int unsigned coord, input int unsigned outsz,
                                        input int unsigned src, output int unsigned idx,
                                        output int frac);
    longint unsigned divisor, q;
    divisor = (outsz > 1) ? outsz - 1 : 1;
    q = (longint'(coord) * (src - 1) * 256) / divisor;
    if ((q >> 8) > src - 2) begin
      idx = src - 2;
      frac = 256;
    end else begin
      idx = q >> 8;
      frac = q & 255;
    end
  endfunction

  // One blend step with floor rounding of the weighted difference.
  function automatic int blend(input int a, input int b, input int f);
    int p;
    p = (b - a) * f;
    return a + ((p >= 0) ? p / 256 : -((-p + 255) / 256));
  endfunction

  function automatic logic [ARGB_W-1:0] interpolated_pixel(input int unsigned px,
                                                           input int unsigned py);
    int unsigned xi, yi, base;
    int fx, fy, a, b, c, d, v;
    logic [ARGB_W-1:0] res;
    map_to_source(px, width_reg, SRC_W, xi, fx);
    map_to_source(py, height_reg, SRC_H, yi, fy);
    base = yi * SRC_W + xi;
    res = {ALPHA_OPAQUE, 24'h0};
    for (int k = 0; k < 3; k++) begin
      a = frame_copy[base][16-8*k +: 8];
      b = frame_copy[base+1][16-8*k +: 8];
      c = frame_copy[base+SRC_W][16-8*k +: 8];
      d = frame_copy[base+SRC_W+1][16-8*k +: 8];
      v = blend(blend(a, b, fx), blend(c, d, fx), fy);
      res[16-8*k +: 8] = v[7:0];
    end
    return res;
  endfunction

  // True when every source pixel a request would read has been written.
  function automatic bit sources_ready(input int unsigned px, input int unsigned py);
    int unsigned xi, yi, base;
    int fx, fy;
    map_to_source(px, width_reg, SRC_W, xi, fx);
    map_to_source(py, height_reg, SRC_H, yi, fy);
    base = yi * SRC_W + xi;
    return written[base] && written[base+1] && written[base+SRC_W] &&
           written[base+SRC_W+1];
  endfunction

  // Sends one transaction, with random idle cycles before it unless in the steady phase;
  // valid stays high until the next item or an idle cycle replaces it.
  task automatic send_item(input logic mode, input logic [COORD_W-1:0] px,
                           input logic [COORD_W-1:0] py, input logic [PIX_W-1:0] rgb);
    while (!steady_phase && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    {in_ch.red_in, in_ch.green_in, in_ch.blue_in} <= rgb;
    do @(posedge clk_i); while (!in_ch.ready);
    if (mode == MODE_WRITE) begin
      if (px < SRC_W && py < SRC_H) begin
        frame_copy[py*SRC_W+px] = rgb;
        written[py*SRC_W+px] = 1'b1;
      end
    end else begin
      pending_pixels.push_back(interpolated_pixel(px, py));
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_OUT_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  function automatic logic [PIX_W-1:0] random_rgb();
    return PIX_W'($urandom);
  endfunction

  // Fills a block of source rows so that requests landing there are defined.
  task automatic fill_rows(input int unsigned first, input int unsigned count,
                           input int unsigned cols);
    for (int unsigned y = first; y < first + count; y++)
      for (int unsigned x = 0; x < cols; x++) send_item(MODE_WRITE, x, y, random_rgb());
  endtask

  // Directed: extremes of the bytes, the corners, writes outside the frame.
  task automatic test_directed();
    fill_rows(0, 2, 4);
    fill_rows(SRC_H - 2, 2, 0);
    for (int unsigned x = SRC_W - 2; x < SRC_W; x++) begin
      send_item(MODE_WRITE, x, SRC_H - 2, 24'hFFFFFF);
      send_item(MODE_WRITE, x, SRC_H - 1, 24'h000000);
    end
    send_item(MODE_WRITE, 12'hFFF, 12'hFFF, 24'hA5A5A5);
    send_item(MODE_WRITE, SRC_W, 0, 24'h5A5A5A);
    send_item(MODE_WRITE, 0, SRC_H, 24'h123456);
    send_item(MODE_REQUEST, 0, 0, '0);
    send_item(MODE_REQUEST, 1, 0, '0);
    send_item(MODE_REQUEST, 319, 239, '0);
    send_item(MODE_REQUEST, 12'hFFF, 12'hFFF, 24'hFFFFFF);
  endtask

  // Output sizes of zero, one and 4096 all end up on the edges.
  task automatic test_size_extremes();
    write_size(CFG_OUT_WIDTH, 1);
    write_size(CFG_OUT_HEIGHT, 1);
    send_item(MODE_REQUEST, 0, 0, '0);
    send_item(MODE_REQUEST, 12'hFFF, 12'hFFF, '0);
    write_size(CFG_OUT_WIDTH, 0);
    write_size(CFG_OUT_HEIGHT, 0);
    send_item(MODE_REQUEST, 0, 0, '0);
    write_size(CFG_OUT_WIDTH, 4096);
    write_size(CFG_OUT_HEIGHT, 4096);
    send_item(MODE_REQUEST, 0, 0, '0);
    send_item(MODE_REQUEST, 4095, 4095, '0);
    // A height above 4096 keeps the top rows for small row numbers.
    write_size(CFG_OUT_HEIGHT, 13'h1FFF);
    send_item(MODE_REQUEST, 20, 0, '0);
  endtask

  // Random traffic over a small written region with a given output size.
  task automatic test_random_phase(input int items, input logic [CFG_W-1:0] w,
                                   input logic [CFG_W-1:0] h);
    int unsigned px, py;
    write_size(CFG_OUT_WIDTH, w);
    write_size(CFG_OUT_HEIGHT, h);
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(9) == 0) send_item(MODE_WRITE, $urandom, $urandom, random_rgb());
        else send_item(MODE_WRITE, $urandom_range(7), $urandom_range(3), random_rgb());
      end else begin
        // Requests only where the four source pixels are already written.
        do begin
          px = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(w);
          py = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(h);
        end while (!sources_ready(px, py) && (px = $urandom_range(1)) >= 0
                   && (py = 0) >= 0 && !sources_ready(px, py));
        send_item(MODE_REQUEST, px, py, random_rgb());
      end
    end
  endtask

  // The receiver holds off while the sender keeps offering requests.
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (300) @(negedge clk_i);
        sink_hold = 1'b0;
      end
      begin
        steady_phase = 1'b1;
        for (int n = 0; n < 80; n++) send_item(MODE_REQUEST, 0, 0, '0);
        steady_phase = 1'b0;
      end
    join
    wait_drained();
  endtask

  // Receiver: random stalls, and the comparison of each accepted result.
  always @(negedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= !sink_hold && (steady_phase || $urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("argb_word: unexpected result %h", out_ch.argb_word);
        error_count++;
      end else begin
        if (out_ch.argb_word !== pending_pixels[0]) begin
          $error("argb_word: expected %h actual %h", pending_pixels[0], out_ch.argb_word);
          error_count++;
        end
        void'(pending_pixels.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bilinear_frame_upscaler_unit_test: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_size_extremes();
    fill_rows(2, 2, 8);
    test_random_phase(200, 9, 5);
    test_backpressure();
    steady_phase = 1'b1;
    test_random_phase(150, 16, 16);
    steady_phase = 1'b0;
    test_random_phase(200, 2, 2);
    wait_drained();
    if (error_count == 0) $display("bilinear_frame_upscaler_unit_test: clean");
    else $display("bilinear_frame_upscaler_unit_test: errors");
    $finish;
  end

endmodule
